>>> design/cns_pkg.sv
// ============================================================================
// cns_pkg: shared types and constants of the colored noise shaper
// Fixed-point formats, filter coefficients, sequencer types and the step
// program that drives the shared serial multiplier.
// ============================================================================
package cns_pkg;

    // Widths of the sample and filter state.
    localparam int STATE_WIDTH  = 32;
    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC         = 24;
    localparam int CSH          = 30;
    localparam int VSH          = 16;

    // Result of a rounded product, with room for the unsaturated pink sum.
    localparam int QW  = STATE_WIDTH + 4;
    localparam int QMW = QW - 1;

    // Serial multiplier operand and product widths.
    localparam int MUL_AW    = STATE_WIDTH;
    localparam int MUL_CW    = 32;
    localparam int MUL_PW    = MUL_AW + MUL_CW;
    localparam int MUL_CNT_W = $clog2(MUL_CW);

    // Clamped magnitude after the volume stage holds 0 .. 2^FRAC.
    localparam int M_W = FRAC + 1;

    // White sample to Q.FRAC alignment.
    localparam int W_SHIFT = FRAC + 1 - SAMPLE_WIDTH;

    // Configuration registers.
    localparam int MODE_W     = 2;
    localparam int VOL_W      = 17;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam logic REG_NOISE_MODE = 1'b0;
    localparam logic REG_VOLUME     = 1'b1;
    localparam logic [MODE_W-1:0] MODE_WHITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PINK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BROWN = 2'd2;
    localparam logic [VOL_W-1:0]  VOLUME_RESET = 17'd19661;

    // Pink filter storage: six leaky stages and the delayed term.
    localparam int STAGES         = 7;
    localparam int STAGE_IDX_W    = 3;
    localparam logic [STAGE_IDX_W-1:0] PINK_DELAY_IDX = 3'd6;

    // Sequencer step counter and the places where each program ends.
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] PINK_TAIL   = 5'd15;
    localparam logic [STEP_W-1:0] BROWN_TAIL  = 5'd3;
    localparam logic [STEP_W-1:0] WHITE_TAIL  = 5'd0;
    localparam logic [STEP_W-1:0] PINK_LEAKY  = 5'd12;
    localparam logic [STEP_W-1:0] PINK_DIRECT = 5'd12;
    localparam logic [STEP_W-1:0] PINK_DELAY  = 5'd13;
    localparam logic [STEP_W-1:0] BROWN_POLE  = 5'd0;
    localparam logic [STEP_W-1:0] BROWN_GAIN  = 5'd1;

    // Saturation limits in the wide result format.
    localparam logic signed [QW-1:0] SMAX_Q =
        {{(QW-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [QW-1:0] SMIN_Q =
        {{(QW-STATE_WIDTH+1){1'b1}}, {(STATE_WIDTH-1){1'b0}}};

    // Full-scale output value and the clamp limit of one.
    localparam logic [MUL_CW-1:0] FS_C =
        {{(MUL_CW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [M_W-1:0] ONE_M = {1'b1, {FRAC{1'b0}}};
    localparam logic [QMW-1:0] ONE_Q = {{(QMW-M_W){1'b0}}, ONE_M};

    // Coefficients in Q.30, as sign and magnitude.
    localparam logic [MUL_CW-1:0] POLE_MAG [6] = '{
        32'd1072517758, 32'd1066569229, 32'd1040455827,
        32'd930397290,  32'd590558003,  32'd817761773
    };
    localparam logic [5:0] POLE_NEG = 6'b100000;
    localparam logic [MUL_CW-1:0] GAIN_MAG [6] = '{
        32'd59611891,  32'd80612134,  32'd165197327,
        32'd333381374, 32'd572253067, 32'd18144089
    };
    localparam logic [5:0] GAIN_NEG = 6'b100000;
    localparam logic [MUL_CW-1:0] C_DIRECT  = 32'd575740366;
    localparam logic [MUL_CW-1:0] C_DELAY   = 32'd124474595;
    localparam logic [MUL_CW-1:0] C_PINKOUT = 32'd118111601;
    localparam logic [MUL_CW-1:0] C_BPOLE   = 32'd1070520599;
    localparam logic [MUL_CW-1:0] C_BGAIN   = 32'd21474836;
    localparam logic [MUL_CW-1:0] C_BOUT    = 32'd3758096384;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_HOLD
    } t_state;

    // Multiplicand source.
    typedef enum logic [2:0] {
        A_STAGE,
        A_W,
        A_SUM,
        A_BROWN,
        A_Y,
        A_MAG
    } t_asel;

    // Multiplier source.
    typedef enum logic [1:0] {
        C_CONST,
        C_VOLUME,
        C_FS
    } t_csel;

    // Rounding of the product.
    typedef enum logic [1:0] {
        RND_Q30,
        RND_Q16,
        RND_OUT
    } t_rnd;

    // What is done with a rounded product.
    typedef enum logic [2:0] {
        ACT_LOAD,
        ACT_ADD_STAGE,
        ACT_DIRECT,
        ACT_DELAY,
        ACT_ADD_BROWN,
        ACT_Y,
        ACT_VOL,
        ACT_OUT
    } t_act;

    // One step of the program.
    typedef struct packed {
        t_asel                  a_sel;
        t_csel                  c_sel;
        logic                   c_neg;
        logic [MUL_CW-1:0]      c_mag;
        logic [STAGE_IDX_W-1:0] idx;
        t_rnd                   rnd;
        t_act                   act;
    } t_op;

    // Saturate a wide result to the state range.
    function automatic logic signed [STATE_WIDTH-1:0] sat_state(
        input logic signed [QW-1:0] v
    );
        logic signed [STATE_WIDTH-1:0] r;
        if (v > SMAX_Q) begin
            r = SMAX_Q[STATE_WIDTH-1:0];
        end else if (v < SMIN_Q) begin
            r = SMIN_Q[STATE_WIDTH-1:0];
        end else begin
            r = v[STATE_WIDTH-1:0];
        end
        return r;
    endfunction

    // Sign-extend a state value to the wide result format.
    function automatic logic signed [QW-1:0] sext_state(
        input logic signed [STATE_WIDTH-1:0] v
    );
        return {{(QW-STATE_WIDTH){v[STATE_WIDTH-1]}}, v};
    endfunction

    // Step program: every mode ends with the volume step and the output step.
    function automatic t_op cns_program(
        input logic [MODE_W-1:0] mode,
        input logic [STEP_W-1:0] step
    );
        t_op                    op;
        logic [STAGE_IDX_W-1:0] k;
        logic [STEP_W-1:0]      tail;
        op.a_sel = A_Y;
        op.c_sel = C_VOLUME;
        op.c_neg = 1'b0;
        op.c_mag = '0;
        op.idx   = '0;
        op.rnd   = RND_Q16;
        op.act   = ACT_VOL;
        k        = step[STAGE_IDX_W:1];
        case (mode)
            MODE_PINK:  tail = PINK_TAIL;
            MODE_BROWN: tail = BROWN_TAIL;
            default:    tail = WHITE_TAIL;
        endcase
        if (step == tail + STEP_W'(1)) begin
            op.a_sel = A_MAG;
            op.c_sel = C_FS;
            op.rnd   = RND_OUT;
            op.act   = ACT_OUT;
        end else if (step == tail) begin
            // Volume step: keep the defaults.
            op.act = ACT_VOL;
        end else if (mode == MODE_PINK) begin
            op.c_sel = C_CONST;
            op.rnd   = RND_Q30;
            if (step < PINK_LEAKY) begin
                op.idx = k;
                if (!step[0]) begin
                    op.a_sel = A_STAGE;
                    op.c_neg = POLE_NEG[k];
                    op.c_mag = POLE_MAG[k];
                    op.act   = ACT_LOAD;
                end else begin
                    op.a_sel = A_W;
                    op.c_neg = GAIN_NEG[k];
                    op.c_mag = GAIN_MAG[k];
                    op.act   = ACT_ADD_STAGE;
                end
            end else if (step == PINK_DIRECT) begin
                op.a_sel = A_W;
                op.c_mag = C_DIRECT;
                op.act   = ACT_DIRECT;
            end else if (step == PINK_DELAY) begin
                op.a_sel = A_W;
                op.c_mag = C_DELAY;
                op.idx   = PINK_DELAY_IDX;
                op.act   = ACT_DELAY;
            end else begin
                op.a_sel = A_SUM;
                op.c_mag = C_PINKOUT;
                op.act   = ACT_Y;
            end
        end else if (mode == MODE_BROWN) begin
            op.c_sel = C_CONST;
            op.rnd   = RND_Q30;
            if (step == BROWN_POLE) begin
                op.a_sel = A_BROWN;
                op.c_mag = C_BPOLE;
                op.act   = ACT_LOAD;
            end else if (step == BROWN_GAIN) begin
                op.a_sel = A_W;
                op.c_mag = C_BGAIN;
                op.act   = ACT_ADD_BROWN;
            end else begin
                op.a_sel = A_BROWN;
                op.c_mag = C_BOUT;
                op.act   = ACT_Y;
            end
        end
        return op;
    endfunction

endpackage

>>> design/cns_stream_ifs.sv
// ============================================================================
// cns_in_if / cns_out_if: sample channels of the colored noise shaper
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ============================================================================
interface cns_in_if import cns_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] white_sample;

    modport source (output valid, output white_sample, input ready);
    modport sink   (input valid, input white_sample, output ready);
endinterface

interface cns_out_if import cns_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] audio_sample;

    modport source (output valid, output audio_sample, input ready);
    modport sink   (input valid, input audio_sample, output ready);
endinterface

>>> design/cns_serial_mul.sv
// ============================================================================
// cns_serial_mul: bit-serial unsigned multiplier
// Shift-and-add over the multiplier bits, one bit per clock, with a narrow
// adder; the full product is held after completion until the next start.
// ============================================================================
module cns_serial_mul import cns_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MUL_AW-1:0] i_a_mag,
    input  logic [MUL_CW-1:0] i_c_mag,
    output logic              o_done,
    output logic [MUL_PW-1:0] o_product
);

    logic [MUL_AW-1:0]    r_a;
    logic [MUL_AW-1:0]    r_acc;
    logic [MUL_AW-1:0]    n_acc;
    logic [MUL_CW-1:0]    r_lo;
    logic [MUL_CW-1:0]    n_lo;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [MUL_AW:0]      w_sum;

    // One partial product per cycle; the sum's low bit shifts into the low half.
    always_comb begin
        w_sum = {1'b0, r_acc} + (r_lo[0] ? {1'b0, r_a} : '0);
        n_acc = w_sum[MUL_AW:1];
        n_lo  = {w_sum[0], r_lo[MUL_CW-1:1]};
    end

    // Control: bit counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + MUL_CNT_W'(1);
                if (r_cnt == MUL_CNT_W'(MUL_CW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and product shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a_mag;
            r_acc <= '0;
            r_lo  <= i_c_mag;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_lo  <= n_lo;
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_acc, r_lo};

endmodule

>>> design/colored_noise_shaper.sv
// ============================================================================
// colored_noise_shaper: white, pink or brown noise from white samples
// Top level with the configuration port, the step sequencer, the filter state
// and the output register.
// ============================================================================
// Each white word runs a short program of products on one bit-serial
// multiplier; each product is issued, runs over the multiplier bits and
// then gives its result. White mode needs 2 products, brown 5, pink 17.
// All products share the one multiplier, so the number of products sets
// the rate. A new word is taken once the previous one reached the output
// register, which may still wait for the sink. noise_mode is at byte
// address 0, volume at 4; both are to be written by the user only while
// no word is in work; the block does not enforce it. Mode 3 behaves as white.
module colored_noise_shaper import cns_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cns_in_if.sink            i_white,
    cns_out_if.source         o_audio,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_state r_state;
    t_state n_state;

    logic [MODE_W-1:0] r_mode;
    logic [MODE_W-1:0] n_mode;
    logic [VOL_W-1:0]  r_volume;
    logic [VOL_W-1:0]  n_volume;
    logic              cfg_write;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    logic signed [STATE_WIDTH-1:0]  r_stage [STAGES];
    logic signed [STATE_WIDTH-1:0]  n_stage [STAGES];
    logic signed [STATE_WIDTH-1:0]  r_brown;
    logic signed [STATE_WIDTH-1:0]  n_brown;
    logic signed [STATE_WIDTH-1:0]  r_w;
    logic signed [STATE_WIDTH-1:0]  n_w;
    logic signed [STATE_WIDTH-1:0]  r_y;
    logic signed [STATE_WIDTH-1:0]  n_y;
    logic signed [QW-1:0]           r_tmp;
    logic signed [QW-1:0]           n_tmp;
    logic signed [QW-1:0]           r_sum;
    logic signed [QW-1:0]           n_sum;
    logic [M_W-1:0]                 r_m;
    logic [M_W-1:0]                 n_m;
    logic                           r_mneg;
    logic                           n_mneg;
    logic                           r_neg;
    logic                           n_neg;
    logic signed [SAMPLE_WIDTH-1:0] r_out;
    logic signed [SAMPLE_WIDTH-1:0] n_out;
    logic                           r_out_valid;
    logic                           n_out_valid;

    t_op                           op;
    logic [STATE_WIDTH-1:0]        a_val;
    logic                          a_neg;
    logic [MUL_AW-1:0]             a_mag;
    logic                          c_neg;
    logic [MUL_CW-1:0]             c_mag;
    logic                          mul_start;
    logic                          mul_done;
    logic [MUL_PW-1:0]             mul_product;
    logic [QMW-1:0]                q_mag;
    logic                          q_even_inc;
    logic signed [QW-1:0]          q_pos;
    logic signed [QW-1:0]          q_s;
    logic signed [QW-1:0]          t_sum;
    logic signed [STATE_WIDTH-1:0] t_sat;
    logic signed [STATE_WIDTH-1:0] w_in;
    logic                          out_free;

    // Configuration port: writes complete in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        n_mode   = r_mode;
        n_volume = r_volume;
        if (cfg_write) begin
            if (paddr[APB_AW-1] == REG_NOISE_MODE) begin
                n_mode = pwdata[MODE_W-1:0];
            end else begin
                n_volume = pwdata[VOL_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[APB_AW-1] == REG_VOLUME) begin
            prdata = {{(APB_DW-VOL_W){1'b0}}, r_volume};
        end else begin
            prdata = {{(APB_DW-MODE_W){1'b0}}, r_mode};
        end
    end

    // Current step of the program.
    assign op = cns_program(r_mode, r_step);

    // Multiplicand selection, split into sign and magnitude.
    always_comb begin
        case (op.a_sel)
            A_STAGE: a_val = r_stage[op.idx];
            A_W:     a_val = r_w;
            A_SUM:   a_val = sat_state(r_sum);
            A_BROWN: a_val = r_brown;
            A_Y:     a_val = r_y;
            default: a_val = '0;
        endcase
        if (op.a_sel == A_MAG) begin
            a_neg = r_mneg;
            a_mag = {{(MUL_AW-M_W){1'b0}}, r_m};
        end else begin
            a_neg = a_val[STATE_WIDTH-1];
            a_mag = a_neg ? (~a_val + {{(STATE_WIDTH-1){1'b0}}, 1'b1}) : a_val;
        end
    end

    // Multiplier selection.
    always_comb begin
        case (op.c_sel)
            C_CONST: begin
                c_neg = op.c_neg;
                c_mag = op.c_mag;
            end
            C_VOLUME: begin
                c_neg = 1'b0;
                c_mag = {{(MUL_CW-VOL_W){1'b0}}, r_volume};
            end
            C_FS: begin
                c_neg = 1'b0;
                c_mag = FS_C;
            end
            default: begin
                c_neg = 1'b0;
                c_mag = '0;
            end
        endcase
    end

    cns_serial_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a_mag   (a_mag),
        .i_c_mag   (c_mag),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    // Rounding of the held product and the signed result.
    always_comb begin
        q_even_inc = mul_product[FRAC-1]
                   & ((|mul_product[FRAC-2:0]) | mul_product[FRAC]);
        case (op.rnd)
            RND_Q30: q_mag = QMW'(mul_product >> CSH) + QMW'(mul_product[CSH-1]);
            RND_Q16: q_mag = QMW'(mul_product >> VSH) + QMW'(mul_product[VSH-1]);
            RND_OUT: q_mag = QMW'(mul_product >> FRAC) + QMW'(q_even_inc);
            default: q_mag = '0;
        endcase
        q_pos = {1'b0, q_mag};
        q_s   = r_neg ? -q_pos : q_pos;
        t_sum = r_tmp + q_s;
        t_sat = sat_state(t_sum);
    end

    // Incoming white word aligned to Q.FRAC.
    assign w_in = {{(STATE_WIDTH-FRAC-1){i_white.white_sample[SAMPLE_WIDTH-1]}},
                   i_white.white_sample, {W_SHIFT{1'b0}}};

    assign out_free = !r_out_valid || o_audio.ready;

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        mul_start   = 1'b0;
        n_neg       = r_neg;
        n_w         = r_w;
        n_y         = r_y;
        n_tmp       = r_tmp;
        n_sum       = r_sum;
        n_stage     = r_stage;
        n_brown     = r_brown;
        n_m         = r_m;
        n_mneg      = r_mneg;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_audio.ready;
        case (r_state)
            ST_IDLE: begin
                if (i_white.valid) begin
                    n_w     = w_in;
                    n_y     = w_in;
                    n_sum   = '0;
                    n_step  = '0;
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                mul_start = 1'b1;
                n_neg     = a_neg ^ c_neg;
                n_state   = ST_WAIT;
            end
            ST_WAIT: begin
                if (mul_done) begin
                    n_step  = r_step + STEP_W'(1);
                    n_state = ST_ISSUE;
                    case (op.act)
                        ACT_LOAD: begin
                            n_tmp = q_s;
                        end
                        ACT_ADD_STAGE: begin
                            n_stage[op.idx] = t_sat;
                            n_sum = r_sum + sext_state(t_sat);
                        end
                        ACT_DIRECT: begin
                            n_sum = r_sum + q_s + sext_state(r_stage[PINK_DELAY_IDX]);
                        end
                        ACT_DELAY: begin
                            n_stage[op.idx] = sat_state(q_s);
                        end
                        ACT_ADD_BROWN: begin
                            n_brown = t_sat;
                        end
                        ACT_Y: begin
                            n_y = sat_state(q_s);
                        end
                        ACT_VOL: begin
                            // Clamp the scaled value to plus or minus one.
                            n_m    = (q_mag > ONE_Q) ? ONE_M : q_mag[M_W-1:0];
                            n_mneg = r_neg;
                        end
                        ACT_OUT: begin
                            n_step = r_step;
                            if (out_free) begin
                                n_out       = q_s[SAMPLE_WIDTH-1:0];
                                n_out_valid = 1'b1;
                                n_state     = ST_IDLE;
                            end else begin
                                n_state = ST_HOLD;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_HOLD: begin
                // The product stays in the multiplier until the output frees up.
                if (out_free) begin
                    n_out       = q_s[SAMPLE_WIDTH-1:0];
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state, configuration and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_mode      <= MODE_WHITE;
            r_volume    <= VOLUME_RESET;
            r_out_valid <= 1'b0;
            r_brown     <= '0;
            for (int i = 0; i < STAGES; i++) begin
                r_stage[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_mode      <= n_mode;
            r_volume    <= n_volume;
            r_out_valid <= n_out_valid;
            r_brown     <= n_brown;
            r_stage     <= n_stage;
        end
    end

    // Working registers of the current word.
    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_w    <= n_w;
        r_y    <= n_y;
        r_tmp  <= n_tmp;
        r_sum  <= n_sum;
        r_m    <= n_m;
        r_mneg <= n_mneg;
        r_out  <= n_out;
    end

    assign i_white.ready        = (r_state == ST_IDLE);
    assign o_audio.valid        = r_out_valid;
    assign o_audio.audio_sample = r_out;

endmodule
